@@ src/ecc_pkg.sv @@
`default_nettype none

package ecc_pkg;

    // Pipeline depth: input register, eleven working stages, result register.
    localparam int NSTAGE = 13;

    localparam int EPOCH_W = 42;
    localparam int LIMIT_W = 41;
    localparam int TDATA_W = 88;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 41'd253402300799;

    typedef struct packed {
        logic                mode;
        logic [EPOCH_W-1:0]  epoch_in;
        logic [15:0]         year_in;
        logic [3:0]          month_in;
        logic [4:0]          day_in;
        logic [4:0]          hour_in;
        logic [5:0]          minute_in;
        logic [5:0]          second_in;
    } in_t;

    typedef struct packed {
        logic                valid_res;
        logic [EPOCH_W-1:0]  epoch_out;
        logic [15:0]         year_out;
        logic [3:0]          month_out;
        logic [4:0]          day_out;
        logic [4:0]          hour_out;
        logic [5:0]          minute_out;
        logic [5:0]          second_out;
    } res_t;

endpackage

`default_nettype wire

@@ src/ecc_datapath.sv @@
`default_nettype none

module ecc_datapath
    import ecc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [NSTAGE-1:0]  load,
    input  wire in_t                in_word,
    input  wire logic [LIMIT_W-1:0] epoch_limit,
    output res_t                    res
);

    // Days from 1 March of year 0 (CACM day base) to 1970-01-01.
    localparam logic [27:0] EPOCH_JDN_OFS = 28'd719469;
    localparam logic [17:0] DAYS_400Y     = 18'd146097;
    localparam logic [10:0] DAYS_4Y       = 11'd1461;

    // Reciprocals: floor forms need one correction step, ceiling forms are exact.
    localparam logic [24:0] RECIP_675  = 25'd25451658;  // floor(2^34 / 675)
    localparam logic [10:0] RECIP_400Y = 11'd1837;      // floor(2^28 / 146097)
    localparam logic [7:0]  RECIP_4Y   = 8'd179;        // floor(2^18 / 1461)
    localparam logic [13:0] RECIP_3600 = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [10:0] RECIP_60   = 11'd1093;      // ceil(2^14 / 15)
    localparam logic [11:0] RECIP_153  = 12'd3427;      // ceil(2^19 / 153)
    localparam logic [8:0]  RECIP_5    = 9'd410;        // ceil(2^11 / 5)
    localparam logic [16:0] RECIP_100  = 17'd83887;     // ceil(2^23 / 100)

    typedef struct packed {
        in_t         inp;
        logic        ok;
        // epoch to calendar
        logic [6:0]  e_lo;
        logic [33:0] x34;
        logic [58:0] p1;
        logic [24:0] qd;
        logic [34:0] qd675;
        logic [24:0] days;
        logic [16:0] sod;
        logic [27:0] t;
        logic [38:0] p4;
        logic [26:0] ph;
        logic [10:0] q1;
        logic [28:0] m1;
        logic [4:0]  hour;
        logic [17:0] t2;
        logic [11:0] remh;
        logic [25:0] p7;
        logic [16:0] y100;
        logic [20:0] pm;
        logic [7:0]  q2;
        logic [17:0] m2;
        logic [5:0]  minute;
        logic [10:0] r2;
        logic [16:0] year;
        logic [5:0]  second;
        logic [10:0] t4;
        logic [22:0] pmon;
        logic [3:0]  mon;
        logic [7:0]  rem153;
        // calendar to epoch
        logic [3:0]  m_adj;
        logic [4:0]  d_adj;
        logic [15:0] y_adj;
        logic [16:0] secmin;
        logic [32:0] pc;
        logic [9:0]  c;
        logic [6:0]  yr;
        logic [24:0] cp;
        logic [15:0] yp;
        logic [24:0] days1;
        logic [41:0] ds;
        logic [41:0] epoch1;
        res_t        res;
    } pipe_t;

    pipe_t pipe_reg  [NSTAGE];
    pipe_t pipe_next [NSTAGE];

    // Days in the months before month m of a year that starts in March.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    always_comb begin
        logic        ok0;
        logic        bad;
        logic [3:0]  m0;
        logic [10:0] r;
        logic [18:0] r1;
        logic [11:0] r2w;
        logic [8:0]  xq;
        pipe_t       s;

        // Stage 0: input register.
        pipe_next[0]     = '0;
        pipe_next[0].inp = in_word;

        // Stage 1: range checks, x / 675 estimate, field adjustments.
        s   = pipe_reg[0];
        ok0 = !s.inp.epoch_in[EPOCH_W-1] && (s.inp.epoch_in[LIMIT_W-1:0] <= epoch_limit);
        s.x34  = s.inp.epoch_in[40:7];
        s.e_lo = s.inp.epoch_in[6:0];
        s.p1   = 59'(s.x34) * 59'(RECIP_675);
        bad = (s.inp.second_in > 6'd60) || (s.inp.minute_in >= 6'd60) ||
              (s.inp.hour_in >= 5'd24) || (s.inp.month_in > 4'd12) ||
              (s.inp.year_in < 16'd1970);
        m0 = (s.inp.month_in == 4'd0) ? 4'd1 : s.inp.month_in;
        s.d_adj = (s.inp.day_in == 5'd0) ? 5'd1 : s.inp.day_in;
        if (m0 > 4'd2) begin
            s.m_adj = m0 - 4'd3;
            s.y_adj = s.inp.year_in;
        end else begin
            s.m_adj = m0 + 4'd9;
            s.y_adj = s.inp.year_in - 16'd1;
        end
        s.pc     = 33'(s.y_adj) * 33'(RECIP_100);
        s.secmin = 17'(s.inp.second_in) + 17'(s.inp.minute_in) * 17'd60 +
                   17'(s.inp.hour_in) * 17'd3600;
        s.ok     = s.inp.mode ? !bad : ok0;
        pipe_next[1] = s;

        // Stage 2: quotient estimate times 675; century split.
        s       = pipe_reg[1];
        s.qd    = s.p1[58:34];
        s.qd675 = 35'(s.qd) * 35'd675;
        s.c     = s.pc[32:23];
        s.yr    = 7'(s.y_adj - 16'(s.c) * 16'd100);
        pipe_next[2] = s;

        // Stage 3: correct the day count, form seconds of the day.
        s = pipe_reg[2];
        r = 11'(35'(s.x34) - s.qd675);
        if (r >= 11'd675) begin
            s.days = s.qd + 25'd1;
            r      = r - 11'd675;
        end else begin
            s.days = s.qd;
        end
        s.sod = {r[9:0], s.e_lo};
        s.cp  = 25'((27'(s.c) * 27'(DAYS_400Y)) >> 2);
        s.yp  = 16'((18'(s.yr) * 18'(DAYS_4Y)) >> 2);
        pipe_next[3] = s;

        // Stage 4: shifted day number and its 400-year estimate; hour estimate.
        s    = pipe_reg[3];
        s.t  = ((28'(s.days) + EPOCH_JDN_OFS) << 2) - 28'd1;
        s.p4 = 39'(s.t) * 39'(RECIP_400Y);
        s.ph = 27'(s.sod[16:4]) * 27'(RECIP_3600);
        s.days1 = 25'(26'(s.cp) + 26'(s.yp) + 26'(s.d_adj) + 26'(days_before(s.m_adj))
                      - 26'(EPOCH_JDN_OFS));
        pipe_next[4] = s;

        // Stage 5
        s      = pipe_reg[4];
        s.q1   = s.p4[38:28];
        s.m1   = 29'(s.q1) * 29'(DAYS_400Y);
        s.hour = 5'(s.ph >> 21);
        s.ds   = 42'(s.days1) * 42'd86400;
        pipe_next[5] = s;

        // Stage 6: correct the 400-year quotient; remainder of the hour.
        s  = pipe_reg[5];
        r1 = 19'(29'(s.t) - s.m1);
        if (r1 >= 19'(DAYS_400Y)) begin
            s.q1 = s.q1 + 11'd1;
            r1   = r1 - 19'(DAYS_400Y);
        end
        s.t2     = r1[17:0] | 18'd3;
        s.remh   = 12'(s.sod - 17'(s.hour) * 17'd3600);
        s.epoch1 = s.ds + 42'(s.secmin);
        pipe_next[6] = s;

        // Stage 7
        s      = pipe_reg[6];
        s.p7   = 26'(s.t2) * 26'(RECIP_4Y);
        s.y100 = 17'(s.q1) * 17'd100;
        s.pm   = 21'(s.remh[11:2]) * 21'(RECIP_60);
        pipe_next[7] = s;

        // Stage 8
        s        = pipe_reg[7];
        s.q2     = s.p7[25:18];
        s.m2     = 18'(s.q2) * 18'(DAYS_4Y);
        s.minute = 6'(s.pm >> 14);
        pipe_next[8] = s;

        // Stage 9: correct the 4-year quotient, assemble the year.
        s   = pipe_reg[8];
        r2w = 12'(s.t2 - s.m2);
        if (r2w >= 12'(DAYS_4Y)) begin
            s.q2 = s.q2 + 8'd1;
            r2w  = r2w - 12'(DAYS_4Y);
        end
        s.r2     = r2w[10:0];
        s.year   = s.y100 + 17'(s.q2);
        s.second = 6'(s.remh - 12'(s.minute) * 12'd60);
        pipe_next[9] = s;

        // Stage 10: day of the March-based year, month estimate.
        s      = pipe_reg[9];
        xq     = 9'((12'(s.r2) + 12'd4) >> 2);
        s.t4   = 11'(11'(xq) * 11'd5 - 11'd3);
        s.pmon = 23'(s.t4) * 23'(RECIP_153);
        pipe_next[10] = s;

        // Stage 11
        s        = pipe_reg[10];
        s.mon    = 4'(s.pmon >> 19);
        s.rem153 = 8'(s.t4 - 11'(s.mon) * 11'd153);
        pipe_next[11] = s;

        // Stage 12: day of month, move to January-based months, result word.
        s     = pipe_reg[11];
        s.res = '0;
        if (s.inp.mode) begin
            s.res.valid_res = s.ok;
            s.res.epoch_out = s.ok ? s.epoch1 : '1;
        end else if (s.ok) begin
            s.res.valid_res  = 1'b1;
            s.res.day_out    = 5'((17'(9'(s.rem153) + 9'd5) * 17'(RECIP_5)) >> 11);
            s.res.hour_out   = s.hour;
            s.res.minute_out = s.minute;
            s.res.second_out = s.second;
            if (s.mon < 4'd10) begin
                s.res.month_out = s.mon + 4'd3;
                s.res.year_out  = s.year[15:0];
            end else begin
                s.res.month_out = s.mon - 4'd9;
                s.res.year_out  = s.year[15:0] + 16'd1;
            end
        end
        pipe_next[12] = s;
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (load[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign res = pipe_reg[NSTAGE-1].res;

endmodule

`default_nettype wire

@@ src/epoch_calendar_converter.sv @@
// Unix time and Gregorian calendar converter.
// Input stream (s_*): one word per conversion. s_tuser selects the direction:
// 0 turns epoch seconds into year, month, day, hour, minute and second;
// 1 turns calendar fields into epoch seconds.
// Output stream (m_*): one result word per input word, in order. m_tuser is
// high when the input was in range and converted; rejected words come out
// with zeroed fields, or with epoch -1 for calendar input.
// The cfg_we / cfg_wdata port sets the largest epoch accepted for conversion;
// write it only while no words are in flight.
// A word passes 13 register stages, the first loaded at acceptance, and the
// constant divisions are spread over them. One word is accepted every cycle
// unless every stage holds a word and the receiver holds m_tready low.
// Reset empties all stages and reloads the epoch limit with 253402300799.
// When the receiver holds m_tready low, the pipeline keeps filling until
// every stage holds a word; only then does s_tready drop.
`default_nettype none

module epoch_calendar_converter
    import ecc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // epoch_in[41:0], year_in[57:42], month_in[61:58], day_in[66:62],
    // hour_in[71:67], minute_in[77:72], second_in[83:78], zero pad
    input  wire logic [TDATA_W-1:0] s_tdata,
    // mode
    input  wire logic               s_tuser,

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // epoch_out[41:0], year_out[57:42], month_out[61:58], day_out[66:62],
    // hour_out[71:67], minute_out[77:72], second_out[83:78], zero pad
    output logic [TDATA_W-1:0]      m_tdata,
    // valid_res
    output logic                    m_tuser
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  vld_next;
    logic [NSTAGE-1:0]  adv;
    in_t                in_word;
    res_t               res;

    // A stage may take a new word when the output is drained or some stage
    // at or after it is empty.
    for (genvar k = 0; k < NSTAGE; k++) begin : g_adv
        assign adv[k] = m_tready || !(&vld_reg[NSTAGE-1:k]);
    end

    always_comb begin
        vld_next[0] = adv[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
        limit_next = cfg_we ? cfg_wdata : limit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            vld_reg   <= vld_next;
            limit_reg <= limit_next;
        end
    end

    always_comb begin
        in_word.mode      = s_tuser;
        in_word.epoch_in  = s_tdata[41:0];
        in_word.year_in   = s_tdata[57:42];
        in_word.month_in  = s_tdata[61:58];
        in_word.day_in    = s_tdata[66:62];
        in_word.hour_in   = s_tdata[71:67];
        in_word.minute_in = s_tdata[77:72];
        in_word.second_in = s_tdata[83:78];
    end

    ecc_datapath u_datapath (
        .aclk        (aclk),
        .load        (adv),
        .in_word     (in_word),
        .epoch_limit (limit_reg),
        .res         (res)
    );

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tuser  = res.valid_res;
    assign m_tdata  = {4'b0, res.second_out, res.minute_out, res.hour_out, res.day_out,
                       res.month_out, res.year_out, res.epoch_out};

endmodule

`default_nettype wire

@@ sim/epoch_calendar_converter_tb.sv @@
module epoch_calendar_converter_tb
    import ecc_pkg::*;
();

    localparam logic MODE_SPLIT = 1'b0;   // epoch seconds to calendar fields
    localparam logic MODE_JOIN  = 1'b1;   // calendar fields to epoch seconds

    localparam longint unsigned JDN_BASE  = 1721119;
    localparam longint unsigned JDN_1970  = 2440588;
    localparam longint unsigned DAYS_400Y = 146097;
    localparam longint unsigned DAYS_4Y   = 1461;

    localparam int PHASE_WORDS = 220;
    localparam int HOLD_CYCLES = 100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        in_t  w;
        bit   typed;
        res_t want;
    } row_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    logic [LIMIT_W-1:0] active_limit = LIMIT_RESET;
    res_t               conversions_due [$];

    bit steady   = 1'b0;
    bit hold_req = 1'b0;
    int hold_left;
    int stall_left;
    int faults;
    int cycle_count;
    int words_checked;
    int words_rejected;
    int split_sent;
    int join_sent;
    int limit_writes;

    epoch_calendar_converter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d conversions still pending",
                     cycle_count, conversions_due.size());
            $display("epoch_calendar_converter test failed");
            $finish;
        end
    end

    // Expected result of one conversion under the current epoch limit.
    function automatic res_t convert_word(in_t w);
        res_t            r;
        longint unsigned e, t, y, mon, x, yr, mo, dd, jdn, secs;
        r = '0;
        if (w.mode == MODE_SPLIT) begin
            e = 64'(w.epoch_in);
            if (!w.epoch_in[EPOCH_W-1] && e <= 64'(active_limit)) begin
                r.second_out = 6'(e % 60);
                e = e / 60;
                r.minute_out = 6'(e % 60);
                e = e / 60;
                r.hour_out = 5'(e % 24);
                e = e / 24;
                // Split the day number into centuries, four-year cycles and a
                // March-based month, as in the classic Julian day method.
                t = ((e + JDN_1970 - JDN_BASE) << 2) - 1;
                y = t / DAYS_400Y;
                t = (t % DAYS_400Y) | 3;
                y = y * 100 + t / DAYS_4Y;
                t = t % DAYS_4Y;
                x = (t + 4) >> 2;
                t = x * 5 - 3;
                mon = t / 153;
                t = (t % 153 + 5) / 5;
                if (mon < 10) begin
                    mon = mon + 3;
                end else begin
                    mon = mon - 9;
                    y = y + 1;
                end
                r.year_out  = 16'(y);
                r.month_out = 4'(mon);
                r.day_out   = 5'(t);
                r.valid_res = 1'b1;
            end
        end else begin
            if (w.second_in > 60 || w.minute_in >= 60 || w.hour_in >= 24 ||
                w.month_in > 12 || w.year_in < 1970) begin
                r.epoch_out = '1;
            end else begin
                yr = 64'(w.year_in);
                mo = (w.month_in == 4'd0) ? 64'd1 : 64'(w.month_in);
                dd = (w.day_in == 5'd0) ? 64'd1 : 64'(w.day_in);
                if (mo > 2) begin
                    mo = mo - 3;
                end else begin
                    mo = mo + 9;
                    yr = yr - 1;
                end
                x = yr / 100;
                yr = yr - 100 * x;
                jdn = ((x * DAYS_400Y) >> 2) + ((yr * DAYS_4Y) >> 2) + dd + JDN_BASE +
                      (mo * 153 + 2) / 5;
                secs = 64'(w.second_in) + 64'(w.minute_in) * 60 + 64'(w.hour_in) * 3600 +
                       (jdn - JDN_1970) * 86400;
                r.epoch_out = EPOCH_W'(secs);
                r.valid_res = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic in_t epoch_word(logic [EPOCH_W-1:0] e);
        in_t w;
        w = '0;
        w.mode = MODE_SPLIT;
        w.epoch_in = e;
        return w;
    endfunction

    function automatic in_t cal_word(int unsigned y, int unsigned mo, int unsigned d,
                                     int unsigned h, int unsigned mi, int unsigned s);
        in_t w;
        w = '0;
        w.mode      = MODE_JOIN;
        w.year_in   = 16'(y);
        w.month_in  = 4'(mo);
        w.day_in    = 5'(d);
        w.hour_in   = 5'(h);
        w.minute_in = 6'(mi);
        w.second_in = 6'(s);
        return w;
    endfunction

    function automatic res_t res_cal(bit v, int unsigned y, int unsigned mo, int unsigned d,
                                     int unsigned h, int unsigned mi, int unsigned s);
        res_t r;
        r = '0;
        r.valid_res  = v;
        r.year_out   = 16'(y);
        r.month_out  = 4'(mo);
        r.day_out    = 5'(d);
        r.hour_out   = 5'(h);
        r.minute_out = 6'(mi);
        r.second_out = 6'(s);
        return r;
    endfunction

    function automatic res_t res_epoch(bit v, logic [EPOCH_W-1:0] e);
        res_t r;
        r = '0;
        r.valid_res = v;
        r.epoch_out = e;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one; none during a steady stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t random_word();
        in_t w;
        int  pick;
        w.mode      = 1'($urandom_range(0, 1));
        w.epoch_in  = EPOCH_W'({$urandom, $urandom});
        w.year_in   = 16'($urandom);
        w.month_in  = 4'($urandom);
        w.day_in    = 5'($urandom);
        w.hour_in   = 5'($urandom);
        w.minute_in = 6'($urandom);
        w.second_in = 6'($urandom);
        pick = $urandom_range(0, 99);
        if (w.mode == MODE_SPLIT) begin
            if (pick < 45) begin
                w.epoch_in = EPOCH_W'({$urandom, $urandom} % (64'(active_limit) + 1));
            end else if (pick < 65) begin
                w.epoch_in = EPOCH_W'(64'(active_limit) + $urandom_range(0, 16) - 8);
            end else if (pick < 80) begin
                w.epoch_in[EPOCH_W-1] = 1'b1;
            end
        end else if (pick < 90) begin
            w.year_in   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1970, 65535))
                                                      : 16'($urandom_range(1970, 2200));
            w.month_in  = 4'($urandom_range(0, 12));
            w.day_in    = 5'($urandom_range(0, 31));
            w.hour_in   = 5'($urandom_range(0, 23));
            w.minute_in = 6'($urandom_range(0, 59));
            w.second_in = 6'($urandom_range(0, 60));
            // Some well-formed dates get one field pushed just out of range.
            if (pick >= 75) begin
                case ($urandom_range(0, 4))
                    0: w.second_in = 6'($urandom_range(61, 63));
                    1: w.minute_in = 6'($urandom_range(60, 63));
                    2: w.hour_in   = 5'($urandom_range(24, 31));
                    3: w.month_in  = 4'($urandom_range(13, 15));
                    default: w.year_in = 16'($urandom_range(0, 1969));
                endcase
            end
        end
        return w;
    endfunction

    task automatic send_word(in_t w, res_t want, int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {4'b0, w.second_in, w.minute_in, w.hour_in, w.day_in, w.month_in,
                    w.year_in, w.epoch_in};
        s_tuser  = w.mode;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        conversions_due.push_back(want);
        if (w.mode == MODE_SPLIT) split_sent++;
        else join_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (conversions_due.size() != 0) @(negedge aclk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        cfg_wdata = v;
        cfg_we = 1'b1;
        active_limit = v;
        limit_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic compare_word(res_t want, res_t got);
        logic [63:0] w [8];
        logic [63:0] g [8];
        string       names [8] = '{"valid_res", "epoch_out", "year_out", "month_out",
                                   "day_out", "hour_out", "minute_out", "second_out"};
        w = '{want.valid_res, want.epoch_out, want.year_out, want.month_out,
              want.day_out, want.hour_out, want.minute_out, want.second_out};
        g = '{got.valid_res, got.epoch_out, got.year_out, got.month_out,
              got.day_out, got.hour_out, got.minute_out, got.second_out};
        for (int i = 0; i < 8; i++) begin
            if (w[i] !== g[i]) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("result word %0d: %s expected 0x%0h, got 0x%0h",
                             words_checked, names[i], w[i], g[i]);
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold on request so the pipeline backs up.
    always @(negedge aclk) begin
        int n;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            n = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
            m_tready = (n == 0);
            stall_left = (n > 0) ? n - 1 : 0;
        end
    end

    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.valid_res  = m_tuser;
            got.epoch_out  = m_tdata[41:0];
            got.year_out   = m_tdata[57:42];
            got.month_out  = m_tdata[61:58];
            got.day_out    = m_tdata[66:62];
            got.hour_out   = m_tdata[71:67];
            got.minute_out = m_tdata[77:72];
            got.second_out = m_tdata[83:78];
            if (conversions_due.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("result word %0d arrived with no conversion pending",
                             words_checked);
            end else begin
                compare_word(conversions_due.pop_front(), got);
            end
            if (!got.valid_res) words_rejected++;
            words_checked++;
        end
    end

    initial begin : stimulus
        row_t               plan [$];
        in_t                w;
        res_t               want;
        logic [LIMIT_W-1:0] limit_plan [6];

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        plan.push_back(row_t'{epoch_word(42'd0), 1'b1,
                              res_cal(1'b1, 1970, 1, 1, 0, 0, 0)});
        plan.push_back(row_t'{epoch_word(42'd86399), 1'b1,
                              res_cal(1'b1, 1970, 1, 1, 23, 59, 59)});
        plan.push_back(row_t'{epoch_word(42'd951782400), 1'b1,
                              res_cal(1'b1, 2000, 2, 29, 0, 0, 0)});
        plan.push_back(row_t'{epoch_word(42'd2147483647), 1'b1,
                              res_cal(1'b1, 2038, 1, 19, 3, 14, 7)});
        plan.push_back(row_t'{epoch_word(EPOCH_W'(LIMIT_RESET)), 1'b1,
                              res_cal(1'b1, 9999, 12, 31, 23, 59, 59)});
        plan.push_back(row_t'{epoch_word(EPOCH_W'(LIMIT_RESET) + 42'd1), 1'b1,
                              res_cal(1'b0, 0, 0, 0, 0, 0, 0)});
        plan.push_back(row_t'{epoch_word('1), 1'b1, res_cal(1'b0, 0, 0, 0, 0, 0, 0)});
        plan.push_back(row_t'{epoch_word({1'b1, 41'd0}), 1'b1,
                              res_cal(1'b0, 0, 0, 0, 0, 0, 0)});
        plan.push_back(row_t'{epoch_word({1'b0, {41{1'b1}}}), 1'b1,
                              res_cal(1'b0, 0, 0, 0, 0, 0, 0)});
        // Calendar fields are don't-care when splitting an epoch.
        w = epoch_word(42'd0);
        w.year_in = '1; w.month_in = '1; w.day_in = '1;
        w.hour_in = '1; w.minute_in = '1; w.second_in = '1;
        plan.push_back(row_t'{w, 1'b1, res_cal(1'b1, 1970, 1, 1, 0, 0, 0)});
        plan.push_back(row_t'{cal_word(1970, 1, 1, 0, 0, 0), 1'b1, res_epoch(1'b1, 42'd0)});
        plan.push_back(row_t'{cal_word(1970, 0, 0, 0, 0, 0), 1'b1, res_epoch(1'b1, 42'd0)});
        plan.push_back(row_t'{cal_word(1970, 1, 1, 0, 0, 60), 1'b1, res_epoch(1'b1, 42'd60)});
        plan.push_back(row_t'{cal_word(2000, 2, 29, 0, 0, 0), 1'b1,
                              res_epoch(1'b1, 42'd951782400)});
        plan.push_back(row_t'{cal_word(2038, 1, 19, 3, 14, 8), 1'b1,
                              res_epoch(1'b1, 42'd2147483648)});
        plan.push_back(row_t'{cal_word(9999, 12, 31, 23, 59, 59), 1'b1,
                              res_epoch(1'b1, EPOCH_W'(LIMIT_RESET))});
        plan.push_back(row_t'{cal_word(1969, 12, 31, 23, 59, 59), 1'b1, res_epoch(1'b0, '1)});
        plan.push_back(row_t'{cal_word(2020, 6, 15, 12, 30, 61), 1'b1, res_epoch(1'b0, '1)});
        plan.push_back(row_t'{cal_word(2020, 6, 15, 12, 60, 0), 1'b1, res_epoch(1'b0, '1)});
        plan.push_back(row_t'{cal_word(2020, 6, 15, 24, 0, 0), 1'b1, res_epoch(1'b0, '1)});
        plan.push_back(row_t'{cal_word(2020, 13, 15, 0, 0, 0), 1'b1, res_epoch(1'b0, '1)});
        w = cal_word(0, 15, 31, 31, 63, 63);
        w.epoch_in = '1;
        plan.push_back(row_t'{w, 1'b1, res_epoch(1'b0, '1)});
        // February 31st rolls over into March.
        plan.push_back(row_t'{cal_word(2023, 2, 31, 8, 0, 0), 1'b0, res_t'('0)});
        plan.push_back(row_t'{cal_word(65535, 12, 31, 23, 59, 59), 1'b0, res_t'('0)});
        plan.push_back(row_t'{cal_word(2024, 0, 15, 1, 2, 3), 1'b0, res_t'('0)});

        foreach (plan[i]) begin
            want = plan[i].typed ? plan[i].want : convert_word(plan[i].w);
            send_word(plan[i].w, want, pick_gap());
        end
        drain();

        limit_plan = '{41'd0, {LIMIT_W{1'b1}}, 41'd86399, LIMIT_W'({$urandom, $urandom}),
                       41'd4102444800, LIMIT_RESET};
        foreach (limit_plan[p]) begin
            write_limit(limit_plan[p]);
            if (p == 1 || p == 4) hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 64 == 0)
                    steady = (n == 0 && (p == 1 || p == 4)) || ($urandom_range(0, 3) == 0);
                w = random_word();
                send_word(w, convert_word(w), pick_gap());
            end
            steady = 1'b0;
            drain();
        end

        repeat (NSTAGE + 10) @(negedge aclk);

        $display("Checked %0d result words: %0d epoch to calendar, %0d calendar to epoch.",
                 words_checked, split_sent, join_sent);
        $display("%0d rejected; epoch limit written %0d times, zero up to the full range.",
                 words_rejected, limit_writes);
        if (faults == 0) begin
            $display("epoch_calendar_converter test passed");
        end else begin
            $display("%0d field mismatches or stray words", faults);
            $display("epoch_calendar_converter test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/ecc_pkg.sv
src/ecc_datapath.sv
src/epoch_calendar_converter.sv
sim/epoch_calendar_converter_tb.sv
